// ===== src/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// shared types and codes of the bitmap block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

	// bitmap entry: used bit and continuation bit
	localparam logic [1:0] ENT_USED  = 2'h1;
	localparam logic [1:0] ENT_CHAIN = 2'h2;
	localparam logic [1:0] ENT_FREE  = 2'h0;

	// request kinds carried in tuser
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_SPACE  = 2'd1,
		ST_ZERO_SIZE = 2'd2,
		ST_NOT_USED  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SEARCH,
		S_MARK,
		S_FREE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic       wr_en;
		logic       rd_en;
		logic [1:0] wr_data;
	} ram_ctl_t;

endpackage

// ===== src/bba_bitmap_ram.sv =====
// ----------------------------------------------------------------------------
// bba_bitmap_ram
// used/continuation bitmap store, one write and one registered read port
// ----------------------------------------------------------------------------
module bba_bitmap_ram #(
	parameter int DEPTH  = 256,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  bba_pkg::ram_ctl_t ctl,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [1:0]        rd_data
);
	import bba_pkg::*;

	logic [1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= ctl.wr_data;
		end
		if (ctl.rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== src/bitmap_block_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// first-fit allocator over a pool of blocks, one used and one chain bit each
// ----------------------------------------------------------------------------
// Each input word is a request: allocate request_size contiguous blocks
// (tuser 0) or free the region starting at block_index (tuser 1); each gives
// exactly one result word with a status, the granted start block and the
// number of blocks in use afterwards. The bitmap lives in a small RAM that
// one sequencer walks one entry per cycle. An allocate searches from block 0
// for the first free run of request_size blocks and then marks it, and a
// failed search walks the whole pool; a free clears the chain starting at
// block_index, and answers not used when that block is not in use; a zero
// size or an out-of-range request answers without walking the bitmap. After
// reset the RAM is swept to all free before the first request is taken.
// tready is high only while the sequencer is idle; the result register lets
// the next request in while the previous result still waits to be taken.
module bitmap_block_allocator #(
	parameter int NUM_BLOCKS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // request_size[15:0], block_index[23:16]
	input  logic        s_axis_tuser,  // mode: 0 allocate, 1 free
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // status[1:0], start_index[9:2],
	                                   // blocks_in_use[18:10], zero pad
);
	import bba_pkg::*;

	localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CW = $clog2(NUM_BLOCKS + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(NUM_BLOCKS - 1);

	state_t state_q, state_d;

	// sequencer registers
	logic [AW-1:0] addr_q;      // read / write / clear address
	logic [AW-1:0] didx_q;      // index of the entry in rd_data
	logic          dvld_q;      // rd_data holds a fresh entry
	logic [CW-1:0] run_q;       // current free run length
	logic [CW-1:0] need_q;      // blocks wanted
	logic [CW-1:0] rem_q;       // blocks still to mark
	logic          first_q;     // first entry of a free walk
	logic [CW-1:0] used_cnt_q;
	status_t       res_status_q;
	logic [AW-1:0] res_start_q;

	// result register
	logic          m_valid_q;
	status_t       m_status_q;
	logic [7:0]    m_start_q;
	logic [8:0]    m_count_q;

	// request fields
	logic          req_mode;
	logic [15:0]   req_size;
	logic [7:0]    req_idx;
	logic          s_accept;

	// ram
	ram_ctl_t      ram_ctl;
	logic [AW-1:0] wr_addr;
	logic [1:0]    rd_data;

	// shared compare unit
	logic          ent_used;
	logic          ent_chain;
	logic [CW-1:0] run_inc;
	logic          hit;
	logic          at_end;
	logic [AW-1:0] hit_start;
	logic          rd_in_range;
	logic          out_load;

	assign req_size = s_axis_tdata[15:0];
	assign req_idx  = s_axis_tdata[23:16];
	assign req_mode = s_axis_tuser;

	assign s_axis_tready = (state_q == S_IDLE);
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	assign ent_used    = |(rd_data & ENT_USED);
	assign ent_chain   = |(rd_data & ENT_CHAIN);
	assign run_inc     = run_q + CW'(1);
	assign hit         = dvld_q && !ent_used && (run_inc == need_q);
	assign at_end      = (didx_q == LAST_IDX);
	assign hit_start   = AW'(CW'(didx_q) + CW'(1) - need_q);
	assign rd_in_range = (32'(addr_q) < NUM_BLOCKS);
	assign out_load    = !m_valid_q || m_axis_tready;
	assign wr_addr     = (state_q == S_FREE) ? didx_q : addr_q;

	bba_bitmap_ram #(
		.DEPTH  (NUM_BLOCKS),
		.ADDR_W (AW)
	) u_ram (
		.clk     (clk),
		.ctl     (ram_ctl),
		.wr_addr (wr_addr),
		.rd_addr (addr_q),
		.rd_data (rd_data)
	);

	// next state and ram control
	always_comb begin
		state_d = state_q;
		ram_ctl = '{wr_en: 1'b0, rd_en: 1'b0, wr_data: ENT_FREE};
		unique case (state_q)
			S_CLEAR: begin
				// power-up sweep to all free
				ram_ctl.wr_en = 1'b1;
				if (addr_q == LAST_IDX) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (s_accept) begin
					if (req_mode == MODE_ALLOC) begin
						if (req_size == 16'd0 || 32'(req_size) > NUM_BLOCKS) begin
							state_d = S_DONE;
						end else begin
							state_d = S_SEARCH;
						end
					end else begin
						if (32'(req_idx) >= NUM_BLOCKS) begin
							state_d = S_DONE;
						end else begin
							state_d = S_FREE;
						end
					end
				end
			end
			S_SEARCH: begin
				ram_ctl.rd_en = rd_in_range;
				if (hit) begin
					state_d = S_MARK;
				end else if (dvld_q && at_end) begin
					state_d = S_DONE;
				end
			end
			S_MARK: begin
				ram_ctl.wr_en   = 1'b1;
				ram_ctl.wr_data = (rem_q == CW'(1)) ? ENT_USED : (ENT_USED | ENT_CHAIN);
				if (rem_q == CW'(1)) begin
					state_d = S_DONE;
				end
			end
			S_FREE: begin
				// reads run one entry ahead of the clearing write
				ram_ctl.rd_en = rd_in_range;
				if (dvld_q) begin
					if (first_q && !ent_used) begin
						state_d = S_DONE;
					end else begin
						ram_ctl.wr_en = 1'b1;
						if (!ent_chain || at_end) begin
							state_d = S_DONE;
						end
					end
				end
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q     <= '0;
			dvld_q     <= 1'b0;
			used_cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					addr_q <= addr_q + AW'(1);
				end
				S_IDLE: begin
					dvld_q <= 1'b0;
					if (s_accept) begin
						addr_q <= (req_mode == MODE_ALLOC) ? '0 : AW'(req_idx);
					end
				end
				S_SEARCH: begin
					if (hit) begin
						// jump back to the run start for marking
						addr_q <= hit_start;
						dvld_q <= 1'b0;
					end else begin
						addr_q <= addr_q + AW'(1);
						dvld_q <= !(dvld_q && at_end);
					end
				end
				S_MARK: begin
					addr_q <= addr_q + AW'(1);
					if (rem_q == CW'(1)) begin
						used_cnt_q <= used_cnt_q + need_q;
					end
				end
				S_FREE: begin
					addr_q <= addr_q + AW'(1);
					dvld_q <= !(dvld_q && ((first_q && !ent_used) || !ent_chain || at_end));
					if (dvld_q && ent_used) begin
						used_cnt_q <= used_cnt_q - CW'(1);
					end
				end
				S_DONE: begin
					dvld_q <= 1'b0;
				end
				default: begin
					dvld_q <= 1'b0;
				end
			endcase
		end
	end

	// payload side of the sequencer
	always_ff @(posedge clk) begin
		didx_q <= addr_q;
		unique case (state_q)
			S_IDLE: begin
				run_q        <= '0;
				first_q      <= 1'b1;
				need_q       <= CW'(req_size);
				res_start_q  <= '0;
				if (req_mode == MODE_ALLOC && req_size == 16'd0) begin
					res_status_q <= ST_ZERO_SIZE;
				end else if (req_mode == MODE_ALLOC && 32'(req_size) > NUM_BLOCKS) begin
					res_status_q <= ST_NO_SPACE;
				end else if (req_mode == MODE_FREE && 32'(req_idx) >= NUM_BLOCKS) begin
					res_status_q <= ST_NOT_USED;
				end else begin
					res_status_q <= ST_OK;
				end
			end
			S_SEARCH: begin
				if (dvld_q) begin
					run_q <= ent_used ? '0 : run_inc;
					if (hit) begin
						rem_q       <= need_q;
						res_start_q <= hit_start;
					end else if (at_end) begin
						res_status_q <= ST_NO_SPACE;
					end
				end
			end
			S_MARK: begin
				rem_q <= rem_q - CW'(1);
			end
			S_FREE: begin
				if (dvld_q) begin
					first_q <= 1'b0;
					if (first_q && !ent_used) begin
						res_status_q <= ST_NOT_USED;
					end
				end
			end
			S_CLEAR, S_DONE: begin
				first_q <= 1'b0;
			end
			default: begin
				first_q <= 1'b0;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_load) begin
			m_status_q <= res_status_q;
			m_start_q  <= 8'(res_start_q);
			m_count_q  <= 9'(used_cnt_q);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {5'd0, m_count_q, m_start_q, m_status_q};

	// checks

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		32'(used_cnt_q) <= NUM_BLOCKS)
		else $error("blocks in use exceeds pool size");

	a_count_moves_only_when_working: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_MARK && state_q != S_FREE) |=> $stable(used_cnt_q))
		else $error("use count changed outside mark or free");

	a_zero_size_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && req_mode == MODE_ALLOC && req_size == 16'd0)
		|=> (state_q == S_DONE && res_status_q == ST_ZERO_SIZE))
		else $error("zero size allocate not rejected at once");

	a_fresh_data_only_when_walking: assert property (@(posedge clk) disable iff (!arst_n)
		dvld_q |-> (state_q == S_SEARCH || state_q == S_FREE))
		else $error("bitmap read pending outside a walk");

endmodule
